// ===== hdl/swarq_pkg.sv =====
// ----------------------------------------------------------------------------
// swarq_pkg
// Shared types and codes for the go-back-N link endpoint.
// ----------------------------------------------------------------------------
package swarq_pkg;

    // event codes of an input beat
    typedef enum logic [2:0] {
        FUNC_DATA  = 3'd0,
        FUNC_ACK   = 3'd1,
        FUNC_SEND  = 3'd2,
        FUNC_TICK  = 3'd3,
        FUNC_IDLE  = 3'd4,
        FUNC_READ  = 3'd5
    } func_t;

    // result kinds
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_ACK     = 2'd2;
    localparam logic [1:0] KIND_DELIVER = 2'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  seq_no;
        logic [3:0]  window_adv;
        logic [31:0] payload;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  seq_out;
        logic [3:0]  window_out;
        logic [31:0] payload_out;
        logic        accepted;
        logic        last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic tick;
        logic retx_start;
        logic retx_emit;
        logic launch_emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_is_tick;
        logic out_free;
        logic timeout_hit;
        logic retx_final;
        logic launch_ok;
        logic launch_more;
    } dp_status_t;

endpackage

// ===== hdl/swarq_datapath.sv =====
// ----------------------------------------------------------------------------
// swarq_datapath
// Window, queue and receive store state, result formation and output register.
// ----------------------------------------------------------------------------
module swarq_datapath #(
    parameter int WINDOW     = 8,
    parameter int SEND_DEPTH = 8,
    parameter int SEQ_BITS   = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  swarq_pkg::in_item_t   in_data,
    input  logic                  out_stall,
    output logic                  out_valid,
    output swarq_pkg::out_item_t  out_data,
    input  logic                  cfg_wr,
    input  logic [15:0]           cfg_data,
    output logic [15:0]           timeout,
    input  swarq_pkg::dp_cmd_t    cmd,
    output swarq_pkg::dp_status_t status
);
    import swarq_pkg::*;

    localparam int SW  = SEQ_BITS;
    localparam int CW  = $clog2(WINDOW + 1);
    localparam int PW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int QCW = $clog2(SEND_DEPTH + 1);
    localparam int QPW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
    localparam int XW  = SW + CW;

    localparam logic [CW-1:0]  WIN_C   = CW'(WINDOW);
    localparam logic [QCW-1:0] DEPTH_C = QCW'(SEND_DEPTH);
    localparam logic [PW-1:0]  WIN_TOP = PW'(WINDOW - 1);
    localparam logic [QPW-1:0] Q_TOP   = QPW'(SEND_DEPTH - 1);

    // storage
    logic [31:0] unacked_pay_mem  [WINDOW];
    logic [15:0] unacked_time_mem [WINDOW];
    logic [31:0] queue_mem        [SEND_DEPTH];
    logic [31:0] recv_mem         [WINDOW];

    in_item_t       in_reg;
    logic [15:0]    timeout_reg, timeout_next;
    logic [15:0]    now_reg, now_next;
    logic [PW-1:0]  uh_reg, uh_next, ut_reg, ut_next;
    logic [CW-1:0]  uc_reg, uc_next;
    logic [SW-1:0]  nseq_reg, nseq_next;
    logic [CW-1:0]  peer_reg, peer_next;
    logic [QPW-1:0] qh_reg, qh_next, qt_reg, qt_next;
    logic [QCW-1:0] qc_reg, qc_next;
    logic [PW-1:0]  rh_reg, rh_next, rt_reg, rt_next;
    logic [CW-1:0]  rc_reg, rc_next;
    logic [SW-1:0]  exp_reg, exp_next;
    logic [CW-1:0]  free_reg, free_next;
    logic           full_reg, full_next;
    logic           rxany_reg, rxany_next;
    logic [PW-1:0]  ri_reg, ri_next;
    logic [CW-1:0]  rcnt_reg, rcnt_next;
    logic [SW-1:0]  rseq_reg, rseq_next;
    logic           out_valid_reg, out_valid_next;
    out_item_t      out_reg, res;

    // derived values
    logic [SW-1:0]  in_seq, base, ack_d, back, exp_prev;
    logic           ack_hit, data_store, data_old, idle_ok;
    logic [CW-1:0]  shift, free_dec;
    logic [CW:0]    hsum, uc_inc;
    logic [15:0]    elapsed;
    logic           emit;
    func_t          fn;

    assign fn         = func_t'(in_reg.func);
    assign in_seq     = SW'(in_reg.seq_no);
    assign base       = nseq_reg - SW'(uc_reg);
    assign ack_d      = in_seq - base;
    assign ack_hit    = XW'(ack_d) < XW'(uc_reg);
    assign shift      = CW'(ack_d) + CW'(1);
    assign hsum       = (CW+1)'(uh_reg) + (CW+1)'(shift);
    assign back       = exp_reg - in_seq;
    assign exp_prev   = exp_reg - SW'(1);
    assign data_store = (in_seq == exp_reg) && (rc_reg < WIN_C);
    assign data_old   = (back != '0) && !back[SW-1];
    assign free_dec   = (free_reg != '0) ? free_reg - CW'(1) : free_reg;
    assign idle_ok    = full_reg && (free_reg != '0) && rxany_reg;
    assign elapsed    = now_reg - unacked_time_mem[uh_reg];
    assign uc_inc     = (CW+1)'(uc_reg) + (CW+1)'(1);

    // status to the controller
    assign status.in_is_tick  = (func_t'(in_data.func) == FUNC_TICK);
    assign status.out_free    = !out_valid_reg || !out_stall;
    assign status.timeout_hit = (uc_reg != '0) && (elapsed >= timeout_reg);
    assign status.retx_final  = (rcnt_reg == uc_reg - CW'(1));
    assign status.launch_ok   = (qc_reg != '0) && (uc_reg < peer_reg) && (uc_reg < WIN_C);
    assign status.launch_more = (qc_reg > QCW'(1)) && (uc_inc < (CW+1)'(peer_reg))
                                && (uc_inc < (CW+1)'(WINDOW));

    assign emit = cmd.exec || cmd.retx_emit || cmd.launch_emit;

    // result formation
    always_comb
    begin
        res = '0;
        res.last = 1'b1;
        if (cmd.exec)
        begin
            case (fn)
                FUNC_DATA:
                begin
                    if (data_store)
                    begin
                        res.kind       = KIND_ACK;
                        res.seq_out    = 8'(in_seq);
                        res.window_out = 4'(free_dec);
                        res.accepted   = 1'b1;
                    end
                    else if (data_old)
                    begin
                        res.kind       = KIND_ACK;
                        res.seq_out    = 8'(exp_prev);
                        res.window_out = 4'(free_reg);
                    end
                end
                FUNC_ACK:  res.accepted = ack_hit;
                FUNC_SEND: res.accepted = (qc_reg < DEPTH_C);
                FUNC_IDLE:
                begin
                    if (idle_ok)
                    begin
                        res.kind       = KIND_ACK;
                        res.seq_out    = 8'(exp_prev);
                        res.window_out = 4'(free_reg);
                        res.accepted   = 1'b1;
                    end
                end
                FUNC_READ:
                begin
                    if (rc_reg != '0)
                    begin
                        res.kind        = KIND_DELIVER;
                        res.payload_out = recv_mem[rh_reg];
                        res.accepted    = 1'b1;
                    end
                end
                default: res.accepted = 1'b0;
            endcase
        end
        else if (cmd.retx_emit)
        begin
            res.kind        = KIND_DATA;
            res.seq_out     = 8'(rseq_reg);
            res.payload_out = unacked_pay_mem[ri_reg];
            res.accepted    = 1'b1;
            res.last        = status.retx_final && !status.launch_ok;
        end
        else if (cmd.launch_emit && status.launch_ok)
        begin
            res.kind        = KIND_DATA;
            res.seq_out     = 8'(nseq_reg);
            res.payload_out = queue_mem[qh_reg];
            res.accepted    = 1'b1;
            res.last        = !status.launch_more;
        end
    end

    // next state of control registers
    always_comb
    begin
        timeout_next   = cfg_wr ? cfg_data : timeout_reg;
        now_next       = now_reg;
        uh_next        = uh_reg;
        ut_next        = ut_reg;
        uc_next        = uc_reg;
        nseq_next      = nseq_reg;
        peer_next      = peer_reg;
        qh_next        = qh_reg;
        qt_next        = qt_reg;
        qc_next        = qc_reg;
        rh_next        = rh_reg;
        rt_next        = rt_reg;
        rc_next        = rc_reg;
        exp_next       = exp_reg;
        free_next      = free_reg;
        full_next      = full_reg;
        rxany_next     = rxany_reg;
        ri_next        = ri_reg;
        rcnt_next      = rcnt_reg;
        rseq_next      = rseq_reg;
        out_valid_next = out_valid_reg;

        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;

        if (cmd.exec)
        begin
            case (fn)
                FUNC_DATA:
                begin
                    if (data_store)
                    begin
                        rt_next    = (rt_reg == WIN_TOP) ? '0 : rt_reg + PW'(1);
                        rc_next    = rc_reg + CW'(1);
                        free_next  = free_dec;
                        exp_next   = exp_reg + SW'(1);
                        rxany_next = 1'b1;
                        if (free_dec == '0)
                            full_next = 1'b1;
                    end
                end
                FUNC_ACK:
                begin
                    peer_next = (8'(in_reg.window_adv) < 8'(WINDOW))
                                ? CW'(in_reg.window_adv) : WIN_C;
                    if (ack_hit)
                    begin
                        uc_next = uc_reg - shift;
                        uh_next = (hsum >= (CW+1)'(WINDOW))
                                  ? PW'(hsum - (CW+1)'(WINDOW)) : PW'(hsum);
                    end
                end
                FUNC_SEND:
                begin
                    if (qc_reg < DEPTH_C)
                    begin
                        qt_next = (qt_reg == Q_TOP) ? '0 : qt_reg + QPW'(1);
                        qc_next = qc_reg + QCW'(1);
                    end
                end
                FUNC_IDLE:
                begin
                    if (idle_ok)
                        full_next = 1'b0;
                end
                FUNC_READ:
                begin
                    if (rc_reg != '0)
                    begin
                        rh_next = (rh_reg == WIN_TOP) ? '0 : rh_reg + PW'(1);
                        rc_next = rc_reg - CW'(1);
                        if (free_reg < WIN_C)
                            free_next = free_reg + CW'(1);
                    end
                end
                default: rc_next = rc_reg;
            endcase
        end

        if (cmd.tick)
            now_next = now_reg + 16'd1;

        if (cmd.retx_start)
        begin
            ri_next   = uh_reg;
            rcnt_next = '0;
            rseq_next = base;
        end

        if (cmd.retx_emit)
        begin
            ri_next   = (ri_reg == WIN_TOP) ? '0 : ri_reg + PW'(1);
            rcnt_next = rcnt_reg + CW'(1);
            rseq_next = rseq_reg + SW'(1);
        end

        if (cmd.launch_emit && status.launch_ok)
        begin
            ut_next   = (ut_reg == WIN_TOP) ? '0 : ut_reg + PW'(1);
            uc_next   = uc_reg + CW'(1);
            nseq_next = nseq_reg + SW'(1);
            qh_next   = (qh_reg == Q_TOP) ? '0 : qh_reg + QPW'(1);
            qc_next   = qc_reg - QCW'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= 16'd5;
            now_reg       <= '0;
            uh_reg        <= '0;
            ut_reg        <= '0;
            uc_reg        <= '0;
            nseq_reg      <= SW'(1);
            peer_reg      <= WIN_C;
            qh_reg        <= '0;
            qt_reg        <= '0;
            qc_reg        <= '0;
            rh_reg        <= '0;
            rt_reg        <= '0;
            rc_reg        <= '0;
            exp_reg       <= SW'(1);
            free_reg      <= WIN_C;
            full_reg      <= 1'b0;
            rxany_reg     <= 1'b0;
            ri_reg        <= '0;
            rcnt_reg      <= '0;
            rseq_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            timeout_reg   <= timeout_next;
            now_reg       <= now_next;
            uh_reg        <= uh_next;
            ut_reg        <= ut_next;
            uc_reg        <= uc_next;
            nseq_reg      <= nseq_next;
            peer_reg      <= peer_next;
            qh_reg        <= qh_next;
            qt_reg        <= qt_next;
            qc_reg        <= qc_next;
            rh_reg        <= rh_next;
            rt_reg        <= rt_next;
            rc_reg        <= rc_next;
            exp_reg       <= exp_next;
            free_reg      <= free_next;
            full_reg      <= full_next;
            rxany_reg     <= rxany_next;
            ri_reg        <= ri_next;
            rcnt_reg      <= rcnt_next;
            rseq_reg      <= rseq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers and stores
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= in_data;
        if (emit)
            out_reg <= res;
        if (cmd.exec && fn == FUNC_SEND && qc_reg < DEPTH_C)
            queue_mem[qt_reg] <= in_reg.payload;
        if (cmd.exec && fn == FUNC_DATA && data_store)
            recv_mem[rt_reg] <= in_reg.payload;
        if (cmd.retx_emit)
            unacked_time_mem[ri_reg] <= now_reg;
        if (cmd.launch_emit && status.launch_ok)
        begin
            unacked_pay_mem[ut_reg]  <= queue_mem[qh_reg];
            unacked_time_mem[ut_reg] <= now_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign timeout   = timeout_reg;

endmodule

// ===== hdl/swarq_control.sv =====
// ----------------------------------------------------------------------------
// swarq_control
// Sequencer: accepts one event, then steps the datapath through its results.
// ----------------------------------------------------------------------------
module swarq_control (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  swarq_pkg::dp_status_t status,
    output swarq_pkg::dp_cmd_t    cmd
);
    import swarq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_TICK   = 6'b000100,
        S_CHECK  = 6'b001000,
        S_RETX   = 6'b010000,
        S_LAUNCH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.in_is_tick ? S_TICK : S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                cmd.tick   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.timeout_hit)
                begin
                    cmd.retx_start = 1'b1;
                    state_next     = S_RETX;
                end
                else
                    state_next = S_LAUNCH;
            end
            S_RETX:
            begin
                if (status.out_free)
                begin
                    cmd.retx_emit = 1'b1;
                    if (status.retx_final)
                        state_next = status.launch_ok ? S_LAUNCH : S_IDLE;
                end
            end
            S_LAUNCH:
            begin
                if (status.out_free)
                begin
                    cmd.launch_emit = 1'b1;
                    if (!status.launch_ok || !status.launch_more)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hdl/sliding_window_arq_endpoint.sv =====
// ----------------------------------------------------------------------------
// sliding_window_arq_endpoint
// One endpoint of a go-back-N sliding-window link, one event at a time.
// ----------------------------------------------------------------------------
// Usage:
// - in channel (in_valid / in_stall / in_data): one event per beat. The block
//   stalls the input from the cycle after a beat until its last result has
//   been loaded into the output register.
// - out channel (out_valid / out_stall / out_data): result beats, the final
//   one of an event marked with last. The output register holds while stalled
//   and the sequencer waits for it.
// - APB port: register 0, retransmit timeout (16 bits), decoded at every address.
// Sequence: a non-tick event is accepted, then gives one result. A tick is
// accepted, advances the time and checks the timeout, then gives its result
// beats one after another, at most WINDOW data beats, since a resent window
// leaves no room to launch. The sequencer emits one data beat per cycle through
// the output register while it is not stalled; stalls on the output hold it.
// Reset: window, queue and receive store empty, sequence numbers start at 1,
// peer window WINDOW, timeout 5; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sliding_window_arq_endpoint #(
    parameter int WINDOW     = 8,
    parameter int SEND_DEPTH = 8,
    parameter int SEQ_BITS   = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  swarq_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output swarq_pkg::out_item_t out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import swarq_pkg::*;

    dp_cmd_t     cmd;
    dp_status_t  status;
    logic        cfg_wr;
    logic [15:0] timeout;

    // register write; one register fills the whole address range
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0 || paddr != 2'd0);
    assign prdata = {16'd0, timeout};

    swarq_control u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    swarq_datapath #(
        .WINDOW     (WINDOW),
        .SEND_DEPTH (SEND_DEPTH),
        .SEQ_BITS   (SEQ_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_wr    (cfg_wr),
        .cfg_data  (pwdata[15:0]),
        .timeout   (timeout),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== hdl/swarq_checker.sv =====
// ----------------------------------------------------------------------------
// swarq_checker
// Port-level checks on the endpoint's channels, bound to the top level.
// ----------------------------------------------------------------------------
module swarq_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input swarq_pkg::out_item_t out_data
);
    import swarq_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    // one event at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an event is in progress");

    // an unfinished event keeps the input stalled
    a_mid_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> in_stall)
        else $error("input open while results still pending");

    // a status result is always the last result of its event
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_STATUS |-> out_data.last)
        else $error("status result not marked last");

endmodule

bind sliding_window_arq_endpoint swarq_checker u_swarq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== dv/tb_sliding_window_arq_endpoint.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_arq_endpoint
// Drives event beats into the go-back-N endpoint, predicts every result beat
// with a local model of the windows and queues, and compares field by field.
// ----------------------------------------------------------------------------
module tb_sliding_window_arq_endpoint;
    import swarq_pkg::*;

    localparam int WIN   = 8;
    localparam int QDEP  = 8;
    localparam int ADDR_TIMEOUT = 0;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       psel;
    logic       penable;
    logic       pwrite;
    logic [1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic       pready;

    sliding_window_arq_endpoint i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // predictor state
    logic [15:0] m_timeout;
    logic [31:0] m_unacked_word [WIN];
    logic [15:0] m_unacked_stamp [WIN];
    int          m_unacked_n;
    logic [7:0]  m_next_seq;
    int          m_peer_win;
    logic [31:0] m_sendq [QDEP];
    int          m_sendq_n;
    logic [31:0] m_rx_store [WIN];
    int          m_rx_n;
    logic [7:0]  m_expect_seq;
    int          m_own_free;
    logic        m_full_flag;
    logic        m_got_data;
    logic [15:0] m_now;

    out_item_t   expected_beats [$];
    int          n_mismatch;
    int          n_results;
    int          n_items;
    int          send_idle_pct;
    int          recv_idle_pct;

    task automatic link_model_reset();
        m_timeout    = 16'd5;
        m_unacked_n  = 0;
        m_next_seq   = 8'd1;
        m_peer_win   = WIN;
        m_sendq_n    = 0;
        m_rx_n       = 0;
        m_expect_seq = 8'd1;
        m_own_free   = WIN;
        m_full_flag  = 1'b0;
        m_got_data   = 1'b0;
        m_now        = 16'd0;
    endtask

    function automatic out_item_t mk_beat(logic [1:0] k, logic [7:0] s, logic [3:0] w,
                                          logic [31:0] p, logic a);
        out_item_t r;
        r.kind = k;
        r.seq_out = s;
        r.window_out = w;
        r.payload_out = p;
        r.accepted = a;
        r.last = 1'b0;
        return r;
    endfunction

    // work out the result beats of one event and advance the model
    task automatic predict_link_event(in_item_t it);
        out_item_t   res [$];
        logic [7:0]  back;
        logic [7:0]  base;
        logic [7:0]  ack_dist;
        logic [31:0] word;
        logic [3:0]  adv;
        int          shift;
        logic        acc;
        case (it.func)
            FUNC_DATA:
            begin
                back = m_expect_seq - it.seq_no;
                if (it.seq_no == m_expect_seq && m_rx_n < WIN)
                begin
                    m_rx_store[m_rx_n] = it.payload;
                    m_rx_n++;
                    if (m_own_free > 0) m_own_free--;
                    m_expect_seq = m_expect_seq + 8'd1;
                    m_got_data = 1'b1;
                    if (m_own_free == 0) m_full_flag = 1'b1;
                    res.push_back(mk_beat(KIND_ACK, it.seq_no, 4'(m_own_free), 0, 1'b1));
                end
                else if (back != 0 && back < 8'd128)
                    res.push_back(mk_beat(KIND_ACK, m_expect_seq - 8'd1,
                                          4'(m_own_free), 0, 1'b0));
                else
                    res.push_back(mk_beat(KIND_STATUS, 0, 0, 0, 1'b0));
            end
            FUNC_ACK:
            begin
                base = m_next_seq - 8'(m_unacked_n);
                ack_dist = it.seq_no - base;
                acc = 1'b0;
                adv = it.window_adv;
                m_peer_win = (adv < WIN) ? adv : WIN;
                if (ack_dist < m_unacked_n)
                begin
                    shift = ack_dist + 1;
                    for (int i = 0; i < m_unacked_n - shift; i++)
                    begin
                        m_unacked_word[i]  = m_unacked_word[i + shift];
                        m_unacked_stamp[i] = m_unacked_stamp[i + shift];
                    end
                    m_unacked_n = m_unacked_n - shift;
                    acc = 1'b1;
                end
                res.push_back(mk_beat(KIND_STATUS, 0, 0, 0, acc));
            end
            FUNC_SEND:
            begin
                acc = 1'b0;
                if (m_sendq_n < QDEP)
                begin
                    m_sendq[m_sendq_n] = it.payload;
                    m_sendq_n++;
                    acc = 1'b1;
                end
                res.push_back(mk_beat(KIND_STATUS, 0, 0, 0, acc));
            end
            FUNC_TICK:
            begin
                m_now = m_now + 16'd1;
                if (m_unacked_n > 0 && 16'(m_now - m_unacked_stamp[0]) >= m_timeout)
                begin
                    base = m_next_seq - 8'(m_unacked_n);
                    for (int i = 0; i < m_unacked_n; i++)
                    begin
                        res.push_back(mk_beat(KIND_DATA, base + 8'(i), 0,
                                              m_unacked_word[i], 1'b1));
                        m_unacked_stamp[i] = m_now;
                    end
                end
                while (m_sendq_n > 0 && m_unacked_n < m_peer_win && m_unacked_n < WIN)
                begin
                    word = m_sendq[0];
                    res.push_back(mk_beat(KIND_DATA, m_next_seq, 0, word, 1'b1));
                    m_next_seq = m_next_seq + 8'd1;
                    m_unacked_word[m_unacked_n]  = word;
                    m_unacked_stamp[m_unacked_n] = m_now;
                    m_unacked_n++;
                    for (int i = 0; i + 1 < m_sendq_n; i++)
                        m_sendq[i] = m_sendq[i + 1];
                    m_sendq_n--;
                end
                if (res.size() == 0)
                    res.push_back(mk_beat(KIND_STATUS, 0, 0, 0, 1'b0));
            end
            FUNC_IDLE:
            begin
                if (m_full_flag && m_own_free > 0 && m_got_data)
                begin
                    m_full_flag = 1'b0;
                    res.push_back(mk_beat(KIND_ACK, m_expect_seq - 8'd1,
                                          4'(m_own_free), 0, 1'b1));
                end
                else
                    res.push_back(mk_beat(KIND_STATUS, 0, 0, 0, 1'b0));
            end
            FUNC_READ:
            begin
                if (m_rx_n > 0)
                begin
                    word = m_rx_store[0];
                    for (int i = 0; i + 1 < m_rx_n; i++)
                        m_rx_store[i] = m_rx_store[i + 1];
                    m_rx_n--;
                    if (m_own_free < WIN) m_own_free++;
                    res.push_back(mk_beat(KIND_DELIVER, 0, 0, word, 1'b1));
                end
                else
                    res.push_back(mk_beat(KIND_STATUS, 0, 0, 0, 1'b0));
            end
            default:
                res.push_back(mk_beat(KIND_STATUS, 0, 0, 0, 1'b0));
        endcase
        res[res.size() - 1].last = 1'b1;
        foreach (res[i])
            expected_beats.push_back(res[i]);
    endtask

    // send one event beat, with random idle cycles before it
    task automatic send_event(logic [2:0] f, logic [7:0] s, logic [3:0] w, logic [31:0] p);
        in_item_t it;
        it.func = f;
        it.seq_no = s;
        it.window_adv = w;
        it.payload = p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_link_event(it);
        n_items++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (3 + 2 * WIN + 4) @(posedge clk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'(ADDR_TIMEOUT * 4);
        pwdata  <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        m_timeout = v;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (expected_beats.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result beat %p", out_data);
                end
                else
                begin
                    if (out_data !== expected_beats[0])
                    begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("result mismatch: expected %p actual %p",
                                     expected_beats[0], out_data);
                    end
                    void'(expected_beats.pop_front());
                end
            end
        end
    end

    // directed: extremes of every event and the special cases
    task automatic test_directed();
        send_event(FUNC_READ, 0, 0, 0);                 // read with empty store
        send_event(FUNC_IDLE, 0, 0, 0);                 // idle with nothing received
        send_event(FUNC_TICK, 0, 0, 0);                 // tick with nothing to do
        send_event(FUNC_ACK, 8'hff, 4'hf, 0);           // stale ack, wide advert
        for (int i = 0; i < 9; i++)                     // fill queue, ninth rejected
            send_event(FUNC_SEND, 0, 0, (i == 0) ? 32'hffff_ffff : $urandom);
        send_event(FUNC_TICK, 0, 0, 0);                 // launch full window
        send_event(FUNC_ACK, 8'd3, 4'd0, 0);            // partial ack, closed window
        send_event(FUNC_ACK, 8'd200, 4'd8, 0);          // future ack
        for (int i = 1; i <= 8; i++)                    // fill receive store
            send_event(FUNC_DATA, 8'(i), 0, (i == 1) ? 32'd0 : $urandom);
        send_event(FUNC_DATA, 8'd9, 0, 32'h1234);       // in order but store full
        send_event(FUNC_DATA, 8'd3, 0, 0);              // old duplicate
        send_event(FUNC_DATA, 8'd100, 0, 0);            // future data
        send_event(FUNC_READ, 0, 0, 0);
        send_event(FUNC_IDLE, 0, 0, 0);                 // window reopened
        send_event(3'd6, 8'hff, 4'hf, 32'hffff_ffff);   // unused codes
        send_event(3'd7, 0, 0, 0);
        wait_drained();
    endtask

    // random link traffic, mostly well formed
    task automatic test_random(int count);
        int          r;
        logic [7:0]  s;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 15)
            begin
                s = m_expect_seq;
                if ($urandom_range(9) < 2) s = 8'($urandom);
                send_event(FUNC_DATA, s, 4'($urandom), $urandom);
            end
            else if (r < 30)
            begin
                s = m_next_seq - 8'(m_unacked_n) + 8'($urandom_range(8));
                if ($urandom_range(9) < 2) s = 8'($urandom);
                send_event(FUNC_ACK, s, 4'($urandom_range(15)), $urandom);
            end
            else if (r < 50)
                send_event(FUNC_SEND, 8'($urandom), 4'($urandom), $urandom);
            else if (r < 75)
                send_event(FUNC_TICK, 8'($urandom), 4'($urandom), $urandom);
            else if (r < 83)
                send_event(FUNC_IDLE, 8'($urandom), 4'($urandom), $urandom);
            else if (r < 97)
                send_event(FUNC_READ, 8'($urandom), 4'($urandom), $urandom);
            else
                send_event(3'($urandom_range(6, 7)), 8'($urandom), 4'($urandom),
                           $urandom);
        end
    endtask

    // one idling profile with a few timeout settings
    task automatic test_phase(int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        write_timeout(16'd1);
        test_random(60);
        wait_drained();
        write_timeout(16'hffff);
        test_random(40);
        wait_drained();
        write_timeout(16'(2 + $urandom_range(6)));
        test_random(60);
        wait_drained();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        n_mismatch = 0;
        n_results  = 0;
        n_items    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        link_model_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_phase(28, 62);
        test_phase(62, 28);
        test_phase(0, 0);
        $display("run covered %0d events and %0d result beats over three idling profiles",
                 n_items, n_results);
        $display("timeouts 1, 65535 and mid values; queue, window and store full cases");
        if (n_mismatch == 0 && expected_beats.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d mismatches, %0d beats missing", n_mismatch, expected_beats.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
